FILE: sv/tun_pkg.sv
`default_nettype none
package tun_pkg;

  // three axes per vector: x, y, z
  localparam int unsigned AXES = 3;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // bit count rounded up to whole bytes
  function automatic int unsigned byte_bits(input int unsigned n);
    byte_bits = ((n + 7) / 8) * 8;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tun_front.sv
`default_nettype none
// Six-stage front end: edges, cross products, magnitudes, squares, sum.
module tun_front import tun_pkg::*; #(
  parameter int unsigned W = 24,
  parameter int unsigned F = 15,
  localparam int unsigned EW = W + 1,
  localparam int unsigned SB = 4 * EW + 2,
  localparam int unsigned LW = 4 * EW + 2 * F + 6
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           up_valid,
  output logic                          up_ready,
  input  wire  [AXES-1:0][W-1:0]        v0,
  input  wire  [AXES-1:0][W-1:0]        v1,
  input  wire  [AXES-1:0][W-1:0]        v2,
  output logic                          down_valid,
  input  wire                           down_ready,
  output logic [SB-1:0]                 s_o,
  output logic [AXES-1:0][LW-1:0]       t_o,
  output logic [AXES-1:0]               neg_o,
  output logic                          deg_o
);

  localparam int unsigned NS = 6;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned SQW = 4 * EW;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || down_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign up_ready   = rdy[0];
  assign down_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 1: edge vectors
  logic [AXES-1:0][EW-1:0] e1_r, e2_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int a = 0; a < AXES; a++) begin
        e1_r[a] <= {v1[a][W-1], v1[a]} - {v0[a][W-1], v0[a]};
        e2_r[a] <= {v2[a][W-1], v2[a]} - {v0[a][W-1], v0[a]};
      end
    end
  end

  // stage 2: six products, n_a = p_a - q_a
  logic [AXES-1:0][PW-1:0] p_r, q_r;
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p_r[AX_X] <= PW'($signed(e1_r[AX_Y]) * $signed(e2_r[AX_Z]));
      q_r[AX_X] <= PW'($signed(e1_r[AX_Z]) * $signed(e2_r[AX_Y]));
      p_r[AX_Y] <= PW'($signed(e1_r[AX_Z]) * $signed(e2_r[AX_X]));
      q_r[AX_Y] <= PW'($signed(e1_r[AX_X]) * $signed(e2_r[AX_Z]));
      p_r[AX_Z] <= PW'($signed(e1_r[AX_X]) * $signed(e2_r[AX_Y]));
      q_r[AX_Z] <= PW'($signed(e1_r[AX_Y]) * $signed(e2_r[AX_X]));
    end
  end

  // stage 3: cross term as sign and magnitude
  logic [AXES-1:0][PW:0]   n_c;
  logic [AXES-1:0][PW:0]   nabs_c;
  logic [AXES-1:0][PW-1:0] mag_r;
  logic [AXES-1:0]         neg3_r, neg4_r, neg5_r, neg6_r;
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      n_c[a]    = {p_r[a][PW-1], p_r[a]} - {q_r[a][PW-1], q_r[a]};
      nabs_c[a] = n_c[a][PW] ? (~n_c[a] + 1'b1) : n_c[a];
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int a = 0; a < AXES; a++) begin
        mag_r[a]  <= nabs_c[a][PW-1:0];
        neg3_r[a] <= n_c[a][PW];
      end
    end
  end

  // stage 4: square split into half-width partial products
  logic [AXES-1:0][PW-1:0] ll_r, lh_r, hh_r;
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int a = 0; a < AXES; a++) begin
        ll_r[a] <= mag_r[a][EW-1:0] * mag_r[a][EW-1:0];
        lh_r[a] <= mag_r[a][EW-1:0] * mag_r[a][PW-1:EW];
        hh_r[a] <= mag_r[a][PW-1:EW] * mag_r[a][PW-1:EW];
      end
      neg4_r <= neg3_r;
    end
  end

  // stage 5: per-axis square
  logic [AXES-1:0][SQW-1:0] sq_r;
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int a = 0; a < AXES; a++) begin
        sq_r[a] <= (SQW'(hh_r[a]) << PW) + (SQW'(lh_r[a]) << (EW + 1)) + SQW'(ll_r[a]);
      end
      neg5_r <= neg4_r;
    end
  end

  // stage 6: squared length, rounding targets n^2 * 2^(2F+2)
  logic [SB-1:0] s_c;
  assign s_c = SB'(sq_r[AX_X]) + SB'(sq_r[AX_Y]) + SB'(sq_r[AX_Z]);

  logic [SB-1:0]           s_r;
  logic [AXES-1:0][LW-1:0] t_r;
  logic                    deg_r;
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s_r   <= s_c;
      deg_r <= (s_c == '0);
      for (int a = 0; a < AXES; a++) begin
        t_r[a] <= LW'(sq_r[a]) << (2 * F + 2);
      end
      neg6_r <= neg5_r;
    end
  end

  assign s_o   = s_r;
  assign t_o   = t_r;
  assign neg_o = neg6_r;
  assign deg_o = deg_r;

endmodule
`default_nettype wire

FILE: sv/tun_cell.sv
`default_nettype none
// One result bit for all three axes. Keeps r^2*s and r*s so the
// exact test (2c-1)^2 * s <= T needs only shifts and adds.
module tun_cell import tun_pkg::*; #(
  parameter int unsigned W = 24,
  parameter int unsigned F = 15,
  parameter int unsigned BIT = 15,
  localparam int unsigned EW = W + 1,
  localparam int unsigned SB = 4 * EW + 2,
  localparam int unsigned LW = 4 * EW + 2 * F + 6
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      up_valid,
  output logic                     up_ready,
  input  wire  [SB-1:0]            s_i,
  input  wire  [AXES-1:0][LW-1:0]  t_i,
  input  wire  [AXES-1:0][LW-1:0]  p_i,
  input  wire  [AXES-1:0][LW-1:0]  q_i,
  input  wire  [AXES-1:0][F:0]     r_i,
  input  wire  [AXES-1:0]          neg_i,
  input  wire                      deg_i,
  output logic                     down_valid,
  input  wire                      down_ready,
  output logic [SB-1:0]            s_o,
  output logic [AXES-1:0][LW-1:0]  t_o,
  output logic [AXES-1:0][LW-1:0]  p_o,
  output logic [AXES-1:0][LW-1:0]  q_o,
  output logic [AXES-1:0][F:0]     r_o,
  output logic [AXES-1:0]          neg_o,
  output logic                     deg_o
);

  logic                    v_r;
  logic [LW-1:0]           s_w;
  logic [AXES-1:0][LW-1:0] cp, cq, lhs, p_nxt, q_nxt;
  logic [AXES-1:0][F:0]    r_nxt;
  logic [AXES-1:0]         take;

  assign up_ready   = !v_r || down_ready;
  assign down_valid = v_r;
  assign s_w        = LW'(s_i);

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      cp[a]   = p_i[a] + (q_i[a] << (BIT + 1)) + (s_w << (2 * BIT));
      cq[a]   = q_i[a] + (s_w << BIT);
      lhs[a]  = (cp[a] << 2) - (cq[a] << 2) + s_w;
      // once r reaches full scale no further bit may be set
      take[a] = ((BIT == F) || !r_i[a][F]) && (lhs[a] <= t_i[a]);
      p_nxt[a] = take[a] ? cp[a] : p_i[a];
      q_nxt[a] = take[a] ? cq[a] : q_i[a];
      r_nxt[a] = r_i[a] | ((F + 1)'(take[a]) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      s_o   <= s_i;
      t_o   <= t_i;
      p_o   <= p_nxt;
      q_o   <= q_nxt;
      r_o   <= r_nxt;
      neg_o <= neg_i;
      deg_o <= deg_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/triangle_unit_normal_top.sv
`default_nettype none
// Path from input word to output word:
//   six front stages, one cell per result bit, one output register.
// Throughput: one triangle per cycle unless output stalls; each stage has its own
//   valid bit, so bubbles close up and input is taken while a finished word waits.
// Reset: rst_n synchronous, active low; clears all valid bits, payload is not reset.
module triangle_unit_normal_top import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned NORMAL_WIDTH = 16
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero fill
  input  wire  [byte_bits(9*COORD_WIDTH)-1:0]        in_tdata,
  output logic                                       out_tvalid,
  input  wire                                        out_tready,
  // normal_x, normal_y, normal_z, zero fill
  output logic [byte_bits(3*NORMAL_WIDTH)-1:0]       out_tdata,
  // degenerate
  output logic                                       out_tuser
);

  localparam int unsigned W   = COORD_WIDTH;
  localparam int unsigned F   = NORMAL_WIDTH - 1;
  localparam int unsigned NW  = NORMAL_WIDTH;
  localparam int unsigned EW  = W + 1;
  localparam int unsigned SB  = 4 * EW + 2;
  localparam int unsigned LW  = 4 * EW + 2 * F + 6;
  localparam int unsigned NC  = F + 1;            // one cell per result bit
  localparam int unsigned ODW = byte_bits(3 * NORMAL_WIDTH);

  // unpack vertices, axis order x, y, z
  logic [AXES-1:0][W-1:0] v0, v1, v2;
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      v0[a] = in_tdata[a*W +: W];
      v1[a] = in_tdata[(AXES + a)*W +: W];
      v2[a] = in_tdata[(2*AXES + a)*W +: W];
    end
  end

  // chain buses, index k feeds cell k
  logic                    cv   [NC+1];
  logic                    crdy [NC+1];
  logic [SB-1:0]           cs   [NC+1];
  logic [AXES-1:0][LW-1:0] ct   [NC+1];
  logic [AXES-1:0][LW-1:0] cp   [NC+1];
  logic [AXES-1:0][LW-1:0] cq   [NC+1];
  logic [AXES-1:0][F:0]    cr   [NC+1];
  logic [AXES-1:0]         cneg [NC+1];
  logic                    cdeg [NC+1];

  tun_front #(.W(W), .F(F)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .v0         (v0),
    .v1         (v1),
    .v2         (v2),
    .down_valid (cv[0]),
    .down_ready (crdy[0]),
    .s_o        (cs[0]),
    .t_o        (ct[0]),
    .neg_o      (cneg[0]),
    .deg_o      (cdeg[0])
  );

  // search starts at r = 0
  assign cp[0] = '0;
  assign cq[0] = '0;
  assign cr[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    tun_cell #(.W(W), .F(F), .BIT(F - k)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (cv[k]),
      .up_ready   (crdy[k]),
      .s_i        (cs[k]),
      .t_i        (ct[k]),
      .p_i        (cp[k]),
      .q_i        (cq[k]),
      .r_i        (cr[k]),
      .neg_i      (cneg[k]),
      .deg_i      (cdeg[k]),
      .down_valid (cv[k+1]),
      .down_ready (crdy[k+1]),
      .s_o        (cs[k+1]),
      .t_o        (ct[k+1]),
      .p_o        (cp[k+1]),
      .q_o        (cq[k+1]),
      .r_o        (cr[k+1]),
      .neg_o      (cneg[k+1]),
      .deg_o      (cdeg[k+1])
    );
  end

  // output register: sign, saturation of +1.0, degenerate forced to zero
  logic                       out_valid_r;
  logic [AXES-1:0][NW-1:0]    norm_r, norm_nxt;
  logic                       deg_r;

  assign crdy[NC] = !out_valid_r || out_tready;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      if (cdeg[NC]) begin
        norm_nxt[a] = '0;
      end else if (cneg[NC][a]) begin
        norm_nxt[a] = NW'(~cr[NC][a] + 1'b1);
      end else if (cr[NC][a][F]) begin
        norm_nxt[a] = {1'b0, {F{1'b1}}};
      end else begin
        norm_nxt[a] = cr[NC][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (crdy[NC]) begin
      out_valid_r <= cv[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (crdy[NC]) begin
      norm_r <= norm_nxt;
      deg_r  <= cdeg[NC];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ODW'(norm_r);
  assign out_tuser  = deg_r;

endmodule
`default_nettype wire

FILE: sv/tun_checker.sv
`default_nettype none
module tun_checker import tun_pkg::*; #(
  parameter int unsigned COORD_WIDTH  = 24,
  parameter int unsigned NORMAL_WIDTH = 16
) (
  input wire                                   clk,
  input wire                                   rst_n,
  input wire                                   in_tready,
  input wire                                   out_tvalid,
  input wire                                   out_tready,
  input wire [byte_bits(3*NORMAL_WIDTH)-1:0]   out_tdata,
  input wire                                   out_tuser
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate word with nonzero normal");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata != '0)
    else $error("valid triangle gave zero normal");

endmodule

bind triangle_unit_normal_top tun_checker #(
  .COORD_WIDTH  (COORD_WIDTH),
  .NORMAL_WIDTH (NORMAL_WIDTH)
) u_tun_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

// Expected normals of accepted triangles, oldest first
class normal_scoreboard;
  typedef struct packed {
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        degen;
  } normal_t;

  normal_t pending_normals[$];
  int      errors;

  // round(|c| * 2^15 / sqrt(s)), ties away, capped at 2^15
  function automatic logic [15:0] unit_mag(input logic [63:0] cmag, input logic [159:0] s);
    logic [159:0] rhs;
    logic [159:0] lhs;
    logic [16:0]  r;
    logic [16:0]  cand;
    rhs = ({96'd0, cmag} * {96'd0, cmag}) << 32;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = r | (17'd1 << b);
      if (cand <= 17'd32768) begin
        lhs = {142'd0, 2 * cand - 1} * {142'd0, 2 * cand - 1} * s;
        if (lhs <= rhs) r = cand;
      end
    end
    return r[15:0];
  endfunction

  function void note_triangle(input logic [215:0] word);
    longint  vert[9];
    longint  e1[3];
    longint  e2[3];
    longint  cr[3];
    logic [63:0]  cmag[3];
    logic [159:0] s;
    logic [15:0]  comp[3];
    logic [15:0]  m;
    normal_t      n;
    for (int i = 0; i < 9; i++) vert[i] = longint'($signed(word[i*24 +: 24]));
    for (int i = 0; i < 3; i++) begin
      e1[i] = vert[3 + i] - vert[i];
      e2[i] = vert[6 + i] - vert[i];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = '0;
    for (int i = 0; i < 3; i++) begin
      cmag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      s += {96'd0, cmag[i]} * {96'd0, cmag[i]};
    end
    if (s == 0) begin
      n = '{16'd0, 16'd0, 16'd0, 1'b1};
    end else begin
      for (int i = 0; i < 3; i++) begin
        m = unit_mag(cmag[i], s);
        // +1.0 saturates, -1.0 fits
        if (cr[i] < 0) comp[i] = -m;
        else comp[i] = (m == 16'h8000) ? 16'h7fff : m;
      end
      n = '{comp[0], comp[1], comp[2], 1'b0};
    end
    pending_normals = {pending_normals, n};
  endfunction

  function void check_normal(input logic [47:0] data, input logic degen);
    normal_t got;
    normal_t want;
    got = '{data[15:0], data[31:16], data[47:32], degen};
    if (pending_normals.size() == 0) begin
      $display("%0t: unexpected word, got %h", $time, got);
      errors++;
      return;
    end
    want = pending_normals.pop_front();
    if (got.nx !== want.nx) begin
      $display("%0t: normal_x exp %h got %h", $time, want.nx, got.nx);
      errors++;
    end
    if (got.ny !== want.ny) begin
      $display("%0t: normal_y exp %h got %h", $time, want.ny, got.ny);
      errors++;
    end
    if (got.nz !== want.nz) begin
      $display("%0t: normal_z exp %h got %h", $time, want.nz, got.nz);
      errors++;
    end
    if (got.degen !== want.degen) begin
      $display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int DRAIN_CYCLES    = 60;   // idle clocks after the final drain
  localparam logic signed [23:0] CMAX = 24'sh7fffff;
  localparam logic signed [23:0] CMIN = 24'sh800000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [215:0] in_tdata = '0;   // v0_x .. v2_z, 24 bits each
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;       // normal_x, normal_y, normal_z
  logic         out_tuser;       // degenerate

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          quiet_cycles   = 0;

  normal_scoreboard sb = new();

  triangle_unit_normal_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random backpressure on the result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watch both handshakes; values read here are the pre-edge ones
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_triangle(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_normal(out_tdata, out_tuser);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL triangle_unit_normal_top");
      $finish;
    end
  end

  // one triangle; valid stays up across back-to-back words
  task automatic send_triangle(input logic signed [23:0] v[9]);
    logic [215:0] word;
    for (int i = 0; i < 9; i++) word[i*24 +: 24] = v[i];
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_verts(input logic signed [23:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
    logic signed [23:0] v[9];
    v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    send_triangle(v);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_normals.size() != 0) @(posedge clk);
  endtask

  // random triangle: full range, small local, collinear, z-flat or extremes
  task automatic send_random();
    logic signed [23:0] v[9];
    int kind;
    int k;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) v[i] = 24'($urandom);
    if (kind < 4) begin
      // small triangle near a random point
      for (int i = 3; i < 9; i++) v[i] = v[i % 3] + $signed(24'($urandom_range(64))) - 24'sd32;
    end else if (kind == 4) begin
      // collinear: v2 = v0 + k*(v1-v0), small edge
      k = $urandom_range(6) - 3;
      for (int i = 0; i < 3; i++) begin
        v[3 + i] = v[i] + $signed(24'($urandom_range(200))) - 24'sd100;
        v[6 + i] = 24'(v[i] + k * (v[3 + i] - v[i]));
      end
    end else if (kind == 5) begin
      // axis-aligned face, exercises full-scale components
      v[2] = v[5];
      v[8] = v[5];
    end else if (kind == 6) begin
      for (int i = 0; i < 9; i++) v[i] = $urandom_range(1) ? CMAX : CMIN;
    end
    send_triangle(v);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate cases
    send_verts(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_verts(5, 5, 5, 5, 5, 5, 9, -3, 7);
    send_verts(0, 0, 0, 1, 2, 3, 2, 4, 6);
    send_verts(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0);
    // unit normals along each axis, both signs (+1.0 saturates)
    send_verts(0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_verts(0, 0, 0, 0, 256, 0, 256, 0, 0);
    send_verts(0, 0, 0, 0, 256, 0, 0, 0, 256);
    send_verts(0, 0, 0, 0, 0, 256, 0, 256, 0);
    send_verts(0, 0, 0, 0, 0, 256, 256, 0, 0);
    send_verts(0, 0, 0, 256, 0, 0, 0, 0, 256);
    // extremes of the coordinate range
    send_verts(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN);
    send_verts(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX);
    send_verts(CMIN, 0, CMAX, CMAX, CMIN, 0, 0, CMAX, CMIN);
    send_verts(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN);
    send_verts(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX);
    // tiny and diagonal faces
    send_verts(0, 0, 0, 1, 0, 0, 0, 1, 0);
    send_verts(0, 0, 0, 1, -1, 0, 1, 0, -1);
    send_verts(-1, -1, -1, 0, 0, -1, -1, 0, 0);
    send_verts(3, 4, 0, 0, 0, 0, 0, 0, 5);

    // hold off until the pipeline is empty
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      repeat (150) send_random();
      if (phase == 1) wait_drained();
    end

    wait_drained();
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS triangle_unit_normal_top");
    end else begin
      $display("FAIL triangle_unit_normal_top");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: filelist.f
sv/tun_pkg.sv
sv/tun_front.sv
sv/tun_cell.sv
sv/triangle_unit_normal_top.sv
sv/tun_checker.sv
verif/testbench.sv
